// ----- rtl/core/accel_tilt_angles_top_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ACCEL_TILT_ANGLES_TOP_MACROS_SVH
`define ACCEL_TILT_ANGLES_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define ATILT_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define ATILT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/atilt_pkg.sv -----
package atilt_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int ANGLE_W          = 15;
    localparam int SUM_W            = 32;
    localparam int RAD_W            = 48;   // sum of squares with 16 fraction bits
    localparam int ROOT_W           = 24;
    localparam int REM_W            = 26;
    localparam int SQRT_BITS_PER    = 4;    // root bits resolved per stage
    localparam int SQRT_STAGES      = ROOT_W / SQRT_BITS_PER;
    localparam int CX_W             = 28;
    localparam int ACC_W            = 24;
    localparam int TABLE_LEN        = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_CENTIDEG     = 9000;
    localparam int FRONT_STAGES     = 3;    // sample, square, sum

    // Stages actually used by the CORDIC for a requested count
    function automatic int cordic_used(input int stages);
        return (stages < TABLE_LEN) ? stages : TABLE_LEN;
    endfunction

    // Register stages from input transfer to output register
    function automatic int total_latency(input int stages);
        return FRONT_STAGES + SQRT_STAGES + cordic_used(stages) + 2;
    endfunction

    // atan(2^-i) in units of 1/256 centidegree
    function automatic logic [ACC_W-1:0] atan_step(input int i);
        logic [ACC_W-1:0] v;
        case (i)
            0:  v = 24'd1152000;
            1:  v = 24'd680065;
            2:  v = 24'd359328;
            3:  v = 24'd182400;
            4:  v = 24'd91554;
            5:  v = 24'd45822;
            6:  v = 24'd22916;
            7:  v = 24'd11459;
            8:  v = 24'd5730;
            9:  v = 24'd2865;
            10: v = 24'd1432;
            11: v = 24'd716;
            12: v = 24'd358;
            13: v = 24'd179;
            14: v = 24'd90;
            15: v = 24'd45;
            16: v = 24'd22;
            17: v = 24'd11;
            18: v = 24'd6;
            19: v = 24'd3;
            20: v = 24'd1;
            21: v = 24'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/atilt_lane.sv -----
module atilt_lane #(
    parameter int STAGES = atilt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] num,
    input  logic [atilt_pkg::SUM_W-1:0]           sum,
    output logic signed [atilt_pkg::ANGLE_W-1:0]  angle
);

    localparam int SQ   = atilt_pkg::SQRT_STAGES;
    localparam int BP   = atilt_pkg::SQRT_BITS_PER;
    localparam int N    = atilt_pkg::cordic_used(STAGES);
    localparam int RW   = atilt_pkg::RAD_W;
    localparam int TW   = atilt_pkg::ROOT_W;
    localparam int MW   = atilt_pkg::REM_W;
    localparam int CW   = atilt_pkg::CX_W;
    localparam int AW   = atilt_pkg::ACC_W;
    localparam int SW   = atilt_pkg::SAMPLE_W;

    // square root pipeline registers
    logic [RW-1:0]        rad_reg  [0:SQ-1];
    logic [MW-1:0]        rem_reg  [0:SQ-1];
    logic [TW-1:0]        root_reg [0:SQ-1];
    logic signed [SW-1:0] sq_num_reg  [0:SQ-1];
    logic                 sq_zero_reg [0:SQ-1];

    // CORDIC pipeline registers
    logic signed [CW-1:0] cx_reg   [0:N-1];
    logic signed [CW-1:0] cy_reg   [0:N-1];
    logic signed [AW-1:0] acc_reg  [0:N-1];
    logic                 cz_reg   [0:N-1];

    logic signed [atilt_pkg::ANGLE_W-1:0] angle_reg;
    logic signed [atilt_pkg::ANGLE_W-1:0] angle_next;

    // Resolve BP root bits per stage, restoring digit by digit
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        logic [RW-1:0]        p_rad;
        logic [MW-1:0]        p_rem;
        logic [TW-1:0]        p_root;
        logic signed [SW-1:0] p_num;
        logic                 p_zero;
        logic [RW-1:0]        rad_next;
        logic [MW-1:0]        rem_next;
        logic [TW-1:0]        root_next;

        if (k == 0) begin : g_first
            assign p_rad  = {sum, 16'd0};
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_num  = num;
            assign p_zero = (sum == '0) && (num == '0);
        end
        else begin : g_rest
            assign p_rad  = rad_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_num  = sq_num_reg[k-1];
            assign p_zero = sq_zero_reg[k-1];
        end

        always_comb
        begin
            logic [MW-1:0] trial;
            rad_next  = p_rad;
            rem_next  = p_rem;
            root_next = p_root;
            for (int j = 0; j < BP; j++)
            begin
                rem_next = {rem_next[MW-3:0], rad_next[RW-1:RW-2]};
                rad_next = {rad_next[RW-3:0], 2'b00};
                trial    = {root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[TW-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[TW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]     <= rad_next;
                rem_reg[k]     <= rem_next;
                root_reg[k]    <= root_next;
                sq_num_reg[k]  <= p_num;
                sq_zero_reg[k] <= p_zero;
            end
        end
    end

    // One vectoring rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [CW-1:0] p_cx;
        logic signed [CW-1:0] p_cy;
        logic signed [AW-1:0] p_acc;
        logic                 p_zero;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [AW-1:0] step;

        if (i == 0) begin : g_first
            assign p_cx   = $signed({{(CW-TW){1'b0}}, root_reg[SQ-1]});
            assign p_cy   = $signed({{(CW-SW-8){sq_num_reg[SQ-1][SW-1]}},
                                     sq_num_reg[SQ-1], 8'd0});
            assign p_acc  = '0;
            assign p_zero = sq_zero_reg[SQ-1];
        end
        else begin : g_rest
            assign p_cx   = cx_reg[i-1];
            assign p_cy   = cy_reg[i-1];
            assign p_acc  = acc_reg[i-1];
            assign p_zero = cz_reg[i-1];
        end

        assign dx   = p_cy >>> i;
        assign dy   = p_cx >>> i;
        assign step = $signed(atilt_pkg::atan_step(i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!p_cy[CW-1])
                begin
                    cx_reg[i]  <= p_cx + dx;
                    cy_reg[i]  <= p_cy - dy;
                    acc_reg[i] <= p_acc + step;
                end
                else
                begin
                    cx_reg[i]  <= p_cx - dx;
                    cy_reg[i]  <= p_cy + dy;
                    acc_reg[i] <= p_acc - step;
                end
                cz_reg[i] <= p_zero;
            end
        end
    end

    // Round to centidegrees, halves away from zero, and saturate
    always_comb
    begin
        logic signed [AW-1:0] acc;
        logic [AW-1:0]        mag;
        logic [AW-1:0]        r;
        logic [atilt_pkg::ANGLE_W-1:0] r_sat;
        acc = acc_reg[N-1];
        mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
        r   = (mag + AW'(128)) >> 8;
        if (r > AW'(atilt_pkg::MAX_CENTIDEG))
            r_sat = atilt_pkg::ANGLE_W'(atilt_pkg::MAX_CENTIDEG);
        else
            r_sat = r[atilt_pkg::ANGLE_W-1:0];
        if (cz_reg[N-1])
            angle_next = '0;
        else if (acc[AW-1])
            angle_next = $signed(-r_sat);
        else
            angle_next = $signed(r_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ----- rtl/core/accel_tilt_angles_top.sv -----
// Tilt angles from one three-axis accelerometer sample: roll = atan2(y, sqrt(x^2+z^2))
// and pitch = -atan2(x, sqrt(y^2+z^2)), both in hundredths of a degree, within
// -9000..9000, and 0 where both atan2 arguments are zero. The pipeline takes one
// sample every cycle unless the output stalls; each sample passes through the three
// front stages (sample, square, sum), six square-root stages of four root bits each,
// one CORDIC rotation per stage and the rounding and output registers. The whole pipe
// holds while a result waits at the output and out_ready is low.
module accel_tilt_angles_top #(
    parameter int CORDIC_STAGES = atilt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [atilt_pkg::ANGLE_W-1:0]  roll_centideg,
    output logic signed [atilt_pkg::ANGLE_W-1:0]  pitch_centideg
);

    localparam int LAT = atilt_pkg::total_latency(CORDIC_STAGES);
    localparam int SW  = atilt_pkg::SAMPLE_W;

    logic en;
    logic vld_reg [0:LAT-1];

    logic signed [SW-1:0] x0_reg, y0_reg, z0_reg;
    logic signed [SW-1:0] x1_reg, y1_reg;
    logic [30:0]          xx_reg, yy_reg, zz_reg;
    logic signed [SW-1:0] x2_reg, y2_reg;
    logic [atilt_pkg::SUM_W-1:0] sr_reg, sp_reg;

    logic signed [31:0] xx_next, yy_next, zz_next;

    logic signed [atilt_pkg::ANGLE_W-1:0] roll_lane, pitch_lane;
    logic signed [atilt_pkg::ANGLE_W-1:0] roll_reg, pitch_reg;

    // Advance everything unless a result is held at the output
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign xx_next = 32'(x0_reg) * 32'(x0_reg);
    assign yy_next = 32'(y0_reg) * 32'(y0_reg);
    assign zz_next = 32'(z0_reg) * 32'(z0_reg);

    // Sample, square, then sum the squares for each lane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= accel_x;
            y0_reg <= accel_y;
            z0_reg <= accel_z;

            xx_reg <= xx_next[30:0];
            yy_reg <= yy_next[30:0];
            zz_reg <= zz_next[30:0];
            x1_reg <= x0_reg;
            y1_reg <= y0_reg;

            sr_reg <= {1'b0, xx_reg} + {1'b0, zz_reg};
            sp_reg <= {1'b0, yy_reg} + {1'b0, zz_reg};
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
        end
    end

    atilt_lane #(
        .STAGES (CORDIC_STAGES)
    ) u_roll (
        .clk   (clk),
        .en    (en),
        .num   (y2_reg),
        .sum   (sr_reg),
        .angle (roll_lane)
    );

    atilt_lane #(
        .STAGES (CORDIC_STAGES)
    ) u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (x2_reg),
        .sum   (sp_reg),
        .angle (pitch_lane)
    );

    // Output register; pitch takes the opposite sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_lane;
            pitch_reg <= -pitch_lane;
        end
    end

    assign out_valid      = vld_reg[LAT-1];
    assign roll_centideg  = roll_reg;
    assign pitch_centideg = pitch_reg;

endmodule

// ----- rtl/core/atilt_check.sv -----
`include "accel_tilt_angles_top_macros.svh"

module atilt_check (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x,
    input logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y,
    input logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [atilt_pkg::ANGLE_W-1:0]  roll_centideg,
    input logic signed [atilt_pkg::ANGLE_W-1:0]  pitch_centideg
);

    localparam logic signed [atilt_pkg::ANGLE_W-1:0] AMAX =
        atilt_pkg::ANGLE_W'(atilt_pkg::MAX_CENTIDEG);

    // Hold a stalled result
    `ATILT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(roll_centideg) && $stable(pitch_centideg), "stalled result changed")

    // Take input whenever the output side can move
    `ATILT_ASSERT(a_in_ready, !out_valid || out_ready, in_ready, "input blocked without output stall")

    // Keep angles within plus or minus ninety degrees
    `ATILT_ASSERT(a_roll_range, out_valid, roll_centideg <= AMAX && roll_centideg >= -AMAX, "roll out of range")

    `ATILT_ASSERT(a_pitch_range, out_valid, pitch_centideg <= AMAX && pitch_centideg >= -AMAX, "pitch out of range")

endmodule

bind accel_tilt_angles_top atilt_check u_atilt_check (.*);

// ----- tb/sv/accel_tilt_angles_top_test.sv -----
`timescale 1ns / 100ps

module accel_tilt_angles_top_test;

    localparam int STAGES       = atilt_pkg::CORDIC_STAGES_DEF;
    localparam int PIPE_LAT     = 3 + 6 + ((STAGES < 24) ? STAGES : 24) + 2;
    localparam int STALL_LIMIT  = 5000;
    localparam int N_RANDOM     = 1280;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [atilt_pkg::ANGLE_W-1:0]  roll_centideg;
    logic signed [atilt_pkg::ANGLE_W-1:0]  pitch_centideg;

    typedef struct packed {
        logic signed [atilt_pkg::ANGLE_W-1:0] roll;
        logic signed [atilt_pkg::ANGLE_W-1:0] pitch;
    } tilt_t;

    tilt_t angle_q[$];
    int    fail_count;
    int    quiet_cycles;
    bit    rx_idle_en;
    bit    tx_idle_en;
    int    hold_off_cycles;

    accel_tilt_angles_top #(.CORDIC_STAGES(STAGES)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .roll_centideg  (roll_centideg),
        .pitch_centideg (pitch_centideg)
    );

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Floor shift right of a signed value
    function automatic longint shr_floor(input longint v, input int s);
        if (v >= 0)
            return v >>> s;
        return ~((~v) >>> s);
    endfunction

    // Bitwise integer square root
    function automatic longint int_sqrt(input longint n);
        longint root;
        longint b;
        root = 0;
        b = longint'(1) <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >>> 1) + b;
            end
            else
                root = root >>> 1;
            b = b >>> 2;
        end
        return root;
    endfunction

    // atan2(num, sqrt(p^2 + q^2)) in centidegrees, rounded and saturated
    function automatic longint tilt_centideg(input longint num, input longint p,
                                             input longint q);
        longint cx, cy, ang, dx, dy, mag, r;
        int     n;
        cx = int_sqrt((p * p + q * q) <<< 16);
        cy = num * 256;
        ang = 0;
        if (cx == 0 && cy == 0)
            return 0;
        n = (STAGES < atilt_pkg::TABLE_LEN) ? STAGES : atilt_pkg::TABLE_LEN;
        for (int i = 0; i < n; i++)
        begin
            dx = shr_floor(cy, i);
            dy = shr_floor(cx, i);
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                ang = ang + longint'(atilt_pkg::atan_step(i));
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                ang = ang - longint'(atilt_pkg::atan_step(i));
            end
        end
        mag = (ang < 0) ? -ang : ang;
        r = (mag + 128) >>> 8;
        if (r > longint'(atilt_pkg::MAX_CENTIDEG))
            r = longint'(atilt_pkg::MAX_CENTIDEG);
        return (ang < 0) ? -r : r;
    endfunction

    function automatic tilt_t predict_tilt(
        input logic signed [atilt_pkg::SAMPLE_W-1:0] x,
        input logic signed [atilt_pkg::SAMPLE_W-1:0] y,
        input logic signed [atilt_pkg::SAMPLE_W-1:0] z);
        tilt_t t;
        t.roll  = atilt_pkg::ANGLE_W'(tilt_centideg(longint'(y), longint'(x),
                                                    longint'(z)));
        t.pitch = atilt_pkg::ANGLE_W'(-tilt_centideg(longint'(x), longint'(y),
                                                     longint'(z)));
        return t;
    endfunction

    // Offer one sample and hold it until the transfer
    task automatic send_sample(input logic signed [atilt_pkg::SAMPLE_W-1:0] x,
                               input logic signed [atilt_pkg::SAMPLE_W-1:0] y,
                               input logic signed [atilt_pkg::SAMPLE_W-1:0] z);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        angle_q.push_back(predict_tilt(x, y, z));
        @(negedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (angle_q.size() != 0)
            @(negedge clk);
    endtask

    // Extremes, zeros and axis-aligned samples
    task automatic test_directed();
        send_sample(0, 0, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 0, 0);
        send_sample(0, 16'sh8000, 0);
        send_sample(0, 0, 16'sh8000);
        send_sample(16'sh7fff, 0, 0);
        send_sample(0, 16'sh7fff, 0);
        send_sample(0, 0, 16'sh7fff);
        send_sample(1, 0, 0);
        send_sample(0, -1, 0);
        send_sample(0, 0, 1);
        send_sample(-1, -1, -1);
        send_sample(16'sh8000, 16'sh7fff, 0);
        send_sample(16'sh7fff, 16'sh8000, 1);
        send_sample(1000, -1000, 16384);
        send_sample(-16384, 16384, 0);
        send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
        wait_drained();
    endtask

    // Receiver holds off while samples keep coming, so the pipe fills and stalls
    task automatic test_backpressure();
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++)
            send_sample(atilt_pkg::SAMPLE_W'($urandom), atilt_pkg::SAMPLE_W'($urandom),
                        atilt_pkg::SAMPLE_W'($urandom));
        wait_drained();
    endtask

    function automatic logic signed [atilt_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return atilt_pkg::SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            2: return 0;
            default: return atilt_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_sample(pick_sample(), pick_sample(), pick_sample());
            // pause until every result is in
            if (i == count / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                n = hold_off_cycles;
                hold_off_cycles = 0;
                repeat (n) @(negedge clk);
            end
            if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        tilt_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (angle_q.size() == 0)
            begin
                $error("result with no sample pending");
                fail_count++;
            end
            else
            begin
                want = angle_q.pop_front();
                if (roll_centideg !== want.roll)
                begin
                    $error("roll_centideg expected %0d actual %0d", want.roll,
                           roll_centideg);
                    fail_count++;
                end
                if (pitch_centideg !== want.pitch)
                begin
                    $error("pitch_centideg expected %0d actual %0d", want.pitch,
                           pitch_centideg);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        fail_count      = 0;
        quiet_cycles    = 0;
        hold_off_cycles = 0;
        rx_idle_en      = 1'b1;
        tx_idle_en      = 1'b1;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        accel_x  = '0;
        accel_y  = '0;
        accel_z  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random(N_RANDOM - 200);
        // last stretch runs without idling
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        test_random(200);
        repeat (PIPE_LAT + 10) @(negedge clk);
        if (fail_count == 0 && angle_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
